>>> hdl/rida_pkg.sv
`timescale 1ns / 1ps

package rida_pkg;

  // bitmap row geometry
  localparam int unsigned ROW_W  = 32;
  localparam int unsigned ROW_BW = 5;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_LIMIT   = 3'd1,
    STAT_NOFREE  = 3'd2,
    STAT_NOTHELD = 3'd3,
    STAT_ZERO    = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_e;

  typedef struct packed {
    logic       action;
    logic [7:0] free_id;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] given_id;
    logic [8:0] live_now;
  } res_t;

endpackage

>>> hdl/rida_bitmap.sv
`timescale 1ns / 1ps

module rida_bitmap import rida_pkg::*; #(
  parameter int unsigned Rows = 8,
  parameter int unsigned RowW = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [RowW-1:0]  rd_row_i,
  input  logic             wr_en_i,
  input  logic [RowW-1:0]  wr_row_i,
  input  logic [ROW_W-1:0] wr_data_i,
  output logic [ROW_W-1:0] rd_data_o
);

  logic [ROW_W-1:0] mem [Rows];
  logic [Rows-1:0]  row_valid_q;
  logic [ROW_W-1:0] rd_q;
  logic             rd_valid_q;
  logic [ROW_W-1:0] rd_init_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_row_i] <= wr_data_i;
    end
    rd_q <= mem[rd_row_i];
  end

  // a row never written reads as its reset pattern: only id 1 held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
      rd_init_q   <= '0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_row_i] <= 1'b1;
      end
      rd_valid_q <= row_valid_q[rd_row_i];
      rd_init_q  <= (rd_row_i == '0) ? ROW_W'(2) : '0;
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : rd_init_q;

endmodule

>>> hdl/rotating_id_allocator_top.sv
`timescale 1ns / 1ps

// channel   | signals                               | handshake
// ----------+---------------------------------------+----------------------------
// request   | start, busy, req_i (action, free_id)  | taken when start && !busy
// result    | res_valid_o, res_o (status, given_id, | one-cycle strobe, no stall
//           |   live_now)                           |
// config    | cfg_valid_i, cfg_ready_o,             | written on valid && ready
//           |   cfg_max_live_i                      |
//
// a free, or an allocate whose first free id lies in the cursor's row, is decided on the first row read;
// the search scans one 32-bit row per cycle from a one-read one-write synchronous memory,
// so an allocate visits rows until it finds a free id or spends its PROBE_LIMIT budget.
// a limit, count-zero or out-of-range-cursor failure is answered from idle, without a search.
// the result strobe shows in the cycle after the decision; the next request may be
// taken in that same cycle. after reset only id 1 is held; no clearing pass is needed.
module rotating_id_allocator_top import rida_pkg::*; #(
  parameter int unsigned ID_SPACE    = 256,
  parameter int unsigned BASE_ID     = 16,
  parameter int unsigned PROBE_LIMIT = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  req_t       req_i,
  output logic       res_valid_o,
  output res_t       res_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [8:0] cfg_max_live_i
);

  localparam int unsigned IdW     = $clog2(ID_SPACE);
  localparam int unsigned PosW    = (IdW > 8) ? IdW : 8;
  localparam int unsigned Rows    = (ID_SPACE + ROW_W - 1) / ROW_W;
  localparam int unsigned RowW    = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned LastRow = (ID_SPACE - 1) / ROW_W;
  localparam int unsigned LastBit = (ID_SPACE - 1) % ROW_W;
  localparam int unsigned CntW    = $clog2(PROBE_LIMIT + 1);
  localparam int unsigned TkW     = (CntW > 6) ? CntW : 6;

  state_e            state_q, state_d;
  logic [8:0]        max_live_q;
  logic [8:0]        count_q, count_d;
  logic [PosW-1:0]   cursor_q, cursor_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [CntW-1:0]   rem_q, rem_d;
  logic              action_q, action_d;
  logic [7:0]        fid_q, fid_d;
  logic              res_valid_q, res_valid_d;
  res_t              res_q, res_d;

  logic              accept;
  logic              alloc_fail_now;
  logic              free_fail_now;
  logic              imm_done;

  logic [RowW-1:0]   rd_row;
  logic              wr_en;
  logic [RowW-1:0]   wr_row;
  logic [ROW_W-1:0]  wr_data;
  logic [ROW_W-1:0]  word;

  logic [RowW-1:0]   pos_row;
  logic [ROW_BW-1:0] lo;
  logic [5:0]        avail;
  logic [5:0]        take;
  logic [5:0]        hi_ex;
  logic [ROW_W-1:0]  cand;
  logic              found;
  logic [ROW_BW-1:0] fbit;
  logic [PosW:0]     pos_sum;
  logic [PosW-1:0]   next_pos;
  logic [CntW-1:0]   rem_left;
  logic [PosW-1:0]   found_id;
  logic              fid_in_range;
  logic              fid_held;
  logic              eval_done;

  rida_bitmap #(
    .Rows (Rows),
    .RowW (RowW)
  ) u_bitmap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_row_i  (rd_row),
    .wr_en_i   (wr_en),
    .wr_row_i  (wr_row),
    .wr_data_i (wr_data),
    .rd_data_o (word)
  );

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign alloc_fail_now = (count_q >= max_live_q) ||
                          ({1'b0, cursor_q} >= (PosW+1)'(ID_SPACE));
  assign free_fail_now  = (count_q == '0);
  assign imm_done       = (req_i.action == ACT_ALLOC) ? alloc_fail_now : free_fail_now;

  // scan of the current row from the probe position
  assign pos_row = RowW'(pos_q >> ROW_BW);
  assign lo      = pos_q[ROW_BW-1:0];
  assign avail   = (pos_row == RowW'(LastRow)) ? (6'(LastBit + 1) - {1'b0, lo})
                                               : (6'(ROW_W) - {1'b0, lo});
  assign take    = (TkW'(rem_q) < TkW'(avail)) ? 6'(rem_q) : avail;
  assign hi_ex   = {1'b0, lo} + take;

  always_comb begin
    for (int b = 0; b < ROW_W; b++) begin
      cand[b] = !word[b] && (6'(b) >= {1'b0, lo}) && (6'(b) < hi_ex);
    end
  end

  always_comb begin
    fbit = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        fbit = ROW_BW'(b);
      end
    end
  end

  assign found    = |cand;
  assign found_id = {pos_q[PosW-1:ROW_BW], fbit};
  assign pos_sum  = (PosW+1)'(pos_q) + (PosW+1)'(take);
  assign next_pos = (pos_sum >= (PosW+1)'(ID_SPACE)) ? PosW'(BASE_ID) : PosW'(pos_sum);
  assign rem_left = rem_q - CntW'(take);

  assign fid_in_range = ({24'b0, fid_q} < 32'(ID_SPACE));
  assign fid_held     = fid_in_range && word[fid_q[ROW_BW-1:0]];

  assign eval_done = (action_q == ACT_FREE) || found || (rem_left == '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !imm_done) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (eval_done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    busy        = (state_q != S_IDLE);
    count_d     = count_q;
    cursor_d    = cursor_q;
    pos_d       = pos_q;
    rem_d       = rem_q;
    action_d    = action_q;
    fid_d       = fid_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    rd_row      = RowW'(next_pos >> ROW_BW);
    wr_en       = 1'b0;
    wr_row      = pos_row;
    wr_data     = word;
    unique case (state_q)
      S_IDLE: begin
        action_d = req_i.action;
        fid_d    = req_i.free_id;
        pos_d    = cursor_q;
        rem_d    = CntW'(PROBE_LIMIT);
        rd_row   = (req_i.action == ACT_FREE) ? RowW'(req_i.free_id >> ROW_BW)
                                              : RowW'(cursor_q >> ROW_BW);
        if (accept && imm_done) begin
          res_valid_d    = 1'b1;
          res_d.given_id = '0;
          res_d.live_now = count_q;
          if (req_i.action == ACT_FREE) begin
            res_d.status = STAT_ZERO;
          end else if (count_q >= max_live_q) begin
            res_d.status = STAT_LIMIT;
          end else begin
            res_d.status = STAT_NOFREE;
          end
        end
      end
      S_EVAL: begin
        res_d.given_id = '0;
        if (action_q == ACT_FREE) begin
          res_valid_d = 1'b1;
          wr_row      = RowW'(fid_q >> ROW_BW);
          if (fid_held) begin
            wr_en                      = 1'b1;
            wr_data[fid_q[ROW_BW-1:0]] = 1'b0;
            count_d                    = count_q - 9'd1;
            res_d.status               = STAT_OK;
            res_d.live_now             = count_q - 9'd1;
          end else begin
            res_d.status   = STAT_NOTHELD;
            res_d.live_now = count_q;
          end
        end else if (found) begin
          res_valid_d        = 1'b1;
          wr_en              = 1'b1;
          wr_data[fbit]      = 1'b1;
          cursor_d           = found_id;
          count_d            = count_q + 9'd1;
          res_d.status       = STAT_OK;
          res_d.given_id     = found_id[7:0];
          res_d.live_now     = count_q + 9'd1;
        end else begin
          // row exhausted: move on, or give up when the probe budget is spent
          pos_d = next_pos;
          rem_d = rem_left;
          if (rem_left == '0) begin
            res_valid_d    = 1'b1;
            res_d.status   = STAT_NOFREE;
            res_d.live_now = count_q;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      max_live_q  <= 9'd256;
      count_q     <= 9'd1;
      cursor_q    <= PosW'(BASE_ID);
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_live_q <= cfg_max_live_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    rem_q    <= rem_d;
    action_q <= action_d;
    fid_q    <= fid_d;
    res_q    <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> sim/rida_grant_checker.sv
`timescale 1ns / 1ps

module rida_grant_checker import rida_pkg::*; #(
  parameter int unsigned ID_SPACE    = 256,
  parameter int unsigned BASE_ID     = 16,
  parameter int unsigned PROBE_LIMIT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  req_t                req_i,
  input  logic                res_valid_i,
  input  res_t                res_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [8:0]          cfg_max_live_i,
  output int unsigned         pending_o,
  output int unsigned         errors_o,
  output logic [ID_SPACE-1:0] held_o
);

  logic [ID_SPACE-1:0] id_held;
  logic [8:0]          live_cnt;
  logic [8:0]          live_cap;
  int unsigned         cursor_id;
  int unsigned         err_cnt;
  res_t                grant_q[$];

  // apply one request to the shadow pool and return the expected result
  function automatic res_t serve(req_t r);
    res_t        o;
    int unsigned probe;
    int unsigned span;
    bit          found;
    o.status   = STAT_OK;
    o.given_id = '0;
    span  = (ID_SPACE > BASE_ID) ? ID_SPACE - BASE_ID : 1;
    found = 1'b0;
    if (r.action == ACT_ALLOC) begin
      if (live_cnt >= live_cap) begin
        o.status = STAT_LIMIT;
      end else begin
        probe = cursor_id;
        for (int n = 0; n < PROBE_LIMIT; n++) begin
          if (probe >= ID_SPACE || !id_held[probe]) begin
            found = probe < ID_SPACE;
            break;
          end
          probe = (probe - BASE_ID + 1) % span + BASE_ID;
        end
        if (found) begin
          id_held[probe] = 1'b1;
          cursor_id      = probe;
          live_cnt       = live_cnt + 9'd1;
          o.given_id     = 8'(probe);
        end else begin
          o.status = STAT_NOFREE;
        end
      end
    end else if (live_cnt == 9'd0) begin
      // count zero wins over the held test
      o.status = STAT_ZERO;
    end else if (r.free_id >= ID_SPACE || !id_held[r.free_id]) begin
      o.status = STAT_NOTHELD;
    end else begin
      id_held[r.free_id] = 1'b0;
      live_cnt           = live_cnt - 9'd1;
    end
    o.live_now = live_cnt;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      id_held = '0;
      if (ID_SPACE > 1) id_held[1] = 1'b1;
      live_cnt  = 9'd1;
      live_cap  = 9'd256;
      cursor_id = BASE_ID;
      err_cnt   = 0;
      grant_q.delete();
      pending_o <= 0;
      errors_o  <= 0;
      held_o    <= '0;
    end else begin
      if (res_valid_i) begin
        if (grant_q.size() == 0) begin
          $error("result with no request outstanding: status %0d given_id %0d",
                 res_i.status, res_i.given_id);
          err_cnt++;
        end else begin
          want = grant_q.pop_front();
          if (res_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_i.status);
            err_cnt++;
          end
          if (res_i.given_id !== want.given_id) begin
            $error("given_id: expected %0d, got %0d", want.given_id, res_i.given_id);
            err_cnt++;
          end
          if (res_i.live_now !== want.live_now) begin
            $error("live_now: expected %0d, got %0d", want.live_now, res_i.live_now);
            err_cnt++;
          end
        end
      end
      if (start_i && !busy_i) grant_q.insert(grant_q.size(), serve(req_i));
      if (cfg_valid_i && cfg_ready_i) live_cap = cfg_max_live_i;
      pending_o <= grant_q.size();
      errors_o  <= err_cnt;
      held_o    <= id_held;
    end
  end

endmodule

>>> sim/tb_rotating_id_allocator_top.sv
`timescale 1ns / 1ps

module tb_rotating_id_allocator_top;
  import rida_pkg::*;

  localparam int unsigned ID_SPACE    = 256;
  localparam int unsigned BASE_ID     = 16;
  localparam int unsigned PROBE_LIMIT = 256;
  localparam int unsigned SETTLE      = 16;
  localparam int unsigned TOTAL       = 1270;
  localparam int unsigned CYCLE_LIMIT = 300000;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       start          = 1'b0;
  req_t       req_i          = '0;
  logic       cfg_valid_i    = 1'b0;
  logic [8:0] cfg_max_live_i = '0;
  logic       busy;
  logic       res_valid_o;
  res_t       res_o;
  logic       cfg_ready_o;

  int unsigned         pending;
  int unsigned         errors;
  logic [ID_SPACE-1:0] held;
  int unsigned         cycles = 0;
  int unsigned         issued = 0;
  int unsigned         idle_pct = 0;

  always #4 clk_i = ~clk_i;

  rotating_id_allocator_top #(
    .ID_SPACE(ID_SPACE), .BASE_ID(BASE_ID), .PROBE_LIMIT(PROBE_LIMIT)
  ) uut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .res_valid_o, .res_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_max_live_i
  );

  rida_grant_checker #(
    .ID_SPACE(ID_SPACE), .BASE_ID(BASE_ID), .PROBE_LIMIT(PROBE_LIMIT)
  ) grant_check (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .req_i,
    .res_valid_i(res_valid_o), .res_i(res_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_max_live_i,
    .pending_o(pending), .errors_o(errors), .held_o(held)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("rotating_id_allocator_top: mismatch");
      $finish;
    end
  end

  // sender gaps: 33 in 100 first, then 88, then none
  task automatic send(input logic act, input logic [7:0] id);
    idle_pct = (issued * 3 < TOTAL) ? 33 : (issued * 3 < 2 * TOTAL) ? 88 : 0;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do begin
        req_i <= req_t'($urandom);
        @(posedge clk_i);
      end while ($urandom_range(0, 99) < idle_pct);
    end
    start <= 1'b1;
    req_i <= '{action: act, free_id: id};
    do @(posedge clk_i); while (busy);
    issued++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_cap(input logic [8:0] cap);
    drain();
    repeat (SETTLE) @(posedge clk_i);
    cfg_max_live_i <= cap;
    cfg_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // held view may lag one request, which now and then yields a not-held free
  function automatic logic [7:0] pick_held();
    int unsigned at;
    at = $urandom_range(0, ID_SPACE - 1);
    for (int k = 0; k < ID_SPACE; k++) begin
      if (held[(at + k) % ID_SPACE]) return 8'((at + k) % ID_SPACE);
    end
    return 8'($urandom);
  endfunction

  task automatic churn(input int unsigned n);
    int unsigned left;
    int unsigned seg;
    bit          fill;
    left = n;
    fill = 1'b1;
    while (left > 0) begin
      seg = $urandom_range(30, 120);
      if (seg > left) seg = left;
      repeat (seg) begin
        if ($urandom_range(0, 99) < (fill ? 90 : 12)) send(ACT_ALLOC, 8'($urandom));
        else if ($urandom_range(0, 3) != 0) send(ACT_FREE, pick_held());
        else send(ACT_FREE, 8'($urandom));
      end
      left -= seg;
      fill = !fill;
      if ($urandom_range(0, 3) == 0) drain();
    end
  endtask

  initial begin
    logic [8:0] caps [6];
    caps = '{9'd200, 9'd0, 9'd1, 9'd241, 9'd100, 9'd256};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send(ACT_FREE, 8'd0);
    send(ACT_FREE, 8'd255);
    send(ACT_ALLOC, 8'hff);
    send(ACT_ALLOC, 8'h00);
    send(ACT_FREE, 8'd17);    // cursor released, next allocate reuses it
    send(ACT_ALLOC, 8'h5a);
    send(ACT_FREE, 8'd1);     // initial id
    send(ACT_FREE, 8'd1);
    send(ACT_FREE, 8'd16);
    send(ACT_FREE, 8'd17);
    send(ACT_FREE, 8'd17);    // count zero beats not held
    send(ACT_ALLOC, 8'ha5);
    write_cap(9'd0);
    send(ACT_ALLOC, 8'd0);
    send(ACT_FREE, 8'd200);
    write_cap(9'd2);
    send(ACT_ALLOC, 8'h33);
    send(ACT_ALLOC, 8'hcc);
    send(ACT_ALLOC, 8'h0f);
    send(ACT_FREE, 8'haa);
    write_cap(9'd256);

    // fill the whole range to hit the exhausted search, then empty it
    repeat (250) send(ACT_ALLOC, 8'($urandom));
    repeat (250) send(ACT_FREE, pick_held());

    foreach (caps[i]) begin
      write_cap(caps[i]);
      churn(125);
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("rotating_id_allocator_top: match");
    end else begin
      $display("rotating_id_allocator_top: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/rida_pkg.sv
hdl/rida_bitmap.sv
hdl/rotating_id_allocator_top.sv
sim/rida_grant_checker.sv
sim/tb_rotating_id_allocator_top.sv
